/* design/symbolic_file_mode_parser_core_assert.svh */
// assertion macros for the symbolic file mode parser
`ifndef SYMBOLIC_FILE_MODE_PARSER_CORE_ASSERT_SVH
`define SYMBOLIC_FILE_MODE_PARSER_CORE_ASSERT_SVH

// property checked on every clock edge outside reset
`define SFMP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sfmp assertion failed");

// condition in one cycle implies a consequence in the next
`define SFMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfmp assertion failed");

`endif

/* design/sfmp_pkg.sv */
// constants shared by the symbolic file mode parser
`default_nettype none

package sfmp_pkg;

  localparam int unsigned ModeW = 12;

  localparam logic [ModeW-1:0] WhoUser   = 12'o5700;
  localparam logic [ModeW-1:0] WhoGroup  = 12'o2070;
  localparam logic [ModeW-1:0] WhoOther  = 12'o0007;
  localparam logic [ModeW-1:0] WhoAll    = 12'o1777;
  localparam logic [ModeW-1:0] PermRead  = 12'o0444;
  localparam logic [ModeW-1:0] PermWrite = 12'o0222;
  localparam logic [ModeW-1:0] PermExec  = 12'o0111;
  localparam logic [ModeW-1:0] PermSetid = 12'o6000;
  localparam logic [ModeW-1:0] PermStick = 12'o1000;

  localparam logic [ModeW-1:0] UmaskReset = 12'o0022;

  // parse phases
  localparam logic [1:0] PhDigits = 2'd0;
  localparam logic [1:0] PhWho    = 2'd1;
  localparam logic [1:0] PhPerm   = 2'd2;
  localparam logic [1:0] PhCopied = 2'd3;

  // pending operator codes
  localparam logic [1:0] OpNone = 2'd0;
  localparam logic [1:0] OpAdd  = 2'd1;
  localparam logic [1:0] OpSub  = 2'd2;
  localparam logic [1:0] OpSet  = 2'd3;

  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChEqual = 8'h3d;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChG     = 8'h67;
  localparam logic [7:0] ChO     = 8'h6f;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChW     = 8'h77;
  localparam logic [7:0] ChX     = 8'h78;

  function automatic logic [ModeW-1:0] apply_op(input logic [1:0]       op,
                                                input logic [ModeW-1:0] bits,
                                                input logic [ModeW-1:0] who,
                                                input logic [ModeW-1:0] cur);
    logic [ModeW-1:0] sel;
    logic [ModeW-1:0] res;
    sel = bits & who;
    res = cur;
    case (op)
      OpAdd:   res = cur | sel;
      OpSub:   res = cur & ~sel;
      OpSet:   res = (cur & ~who) | sel;
      default: res = cur;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/symbolic_file_mode_parser_core.sv */
// symbolic file mode parser: one character per transfer, one result per string
//
//   channel | signals                                  | dir
//   --------+------------------------------------------+-----
//   in      | in_valid_i in_ready_o first_char_i       | in
//           | last_char_i char_code_i orig_mode_i      |
//   out     | out_valid_o out_ready_i new_mode_o       | out
//           | invalid_o                                |
//   cfg     | cfg_we_i cfg_wdata_i (umask)             | in
//
// one character per cycle while the output is not stalled; the parse state is updated in the cycle of the transfer
// the result of the last character is registered in the output register in the cycle after its transfer
// reset gives umask 0022 and an empty string with saved mode zero
// a stalled result blocks every input transfer until the result is taken
`default_nettype none

`include "symbolic_file_mode_parser_core_assert.svh"

module symbolic_file_mode_parser_core
  import sfmp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [ModeW-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             first_char_i,
  input  wire logic             last_char_i,
  input  wire logic [7:0]       char_code_i,
  input  wire logic [ModeW-1:0] orig_mode_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ModeW-1:0]      new_mode_o,
  output logic                  invalid_o
);

  logic [ModeW-1:0] umask_q;
  logic [1:0]       phase_q, phase_d;
  logic [ModeW-1:0] octal_q, octal_d;
  logic [ModeW-1:0] who_q, who_d;
  logic [1:0]       op_q, op_d;
  logic [ModeW-1:0] perm_q, perm_d;
  logic             started_q, started_d;
  logic [ModeW-1:0] cur_q, cur_d;
  logic             err_q, err_d;
  logic [ModeW-1:0] saved_q, saved_d;
  logic             out_valid_q;
  logic [ModeW-1:0] out_mode_q, out_mode_d;
  logic             out_inv_q, out_inv_d;
  logic             in_fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign new_mode_o  = out_mode_q;
  assign invalid_o   = out_inv_q;

  always_comb begin
    logic [1:0]       opc;
    logic             done;
    logic [2:0]       cp;
    logic             is_copy;
    logic [ModeW-1:0] def_who;
    opc     = OpNone;
    done    = 1'b0;
    cp      = 3'd0;
    is_copy = 1'b0;
    def_who = WhoAll & ~umask_q;

    phase_d   = phase_q;
    octal_d   = octal_q;
    who_d     = who_q;
    op_d      = op_q;
    perm_d    = perm_q;
    started_d = started_q;
    cur_d     = cur_q;
    err_d     = err_q;
    saved_d   = saved_q;

    if (first_char_i) begin
      phase_d   = PhDigits;
      octal_d   = '0;
      who_d     = '0;
      op_d      = OpNone;
      perm_d    = '0;
      started_d = 1'b0;
      cur_d     = orig_mode_i;
      saved_d   = orig_mode_i;
      err_d     = 1'b0;
    end

    unique case (char_code_i)
      ChPlus:  opc = OpAdd;
      ChMinus: opc = OpSub;
      ChEqual: opc = OpSet;
      default: opc = OpNone;
    endcase

    if (!err_d) begin
      if (phase_d == PhDigits) begin
        if (char_code_i >= ChZero && char_code_i <= ChSeven) begin
          octal_d = {octal_d[ModeW-4:0], char_code_i[2:0]};
          done    = 1'b1;
        end else begin
          who_d   = '0;
          op_d    = OpNone;
          phase_d = PhWho;
        end
      end
      if (!done) begin
        unique case (phase_d)
          PhWho: begin
            if (char_code_i == ChU) begin
              who_d = who_d | WhoUser;
            end else if (char_code_i == ChG) begin
              who_d = who_d | WhoGroup;
            end else if (char_code_i == ChO) begin
              who_d = who_d | WhoOther;
            end else if (char_code_i == ChA) begin
              who_d = who_d | WhoAll;
            end else if (opc != OpNone) begin
              if (who_d == '0) who_d = def_who;
              op_d      = opc;
              perm_d    = '0;
              started_d = 1'b0;
              phase_d   = PhPerm;
            end else if (char_code_i == ChComma) begin
              who_d   = '0;
              op_d    = OpNone;
              phase_d = PhWho;
            end else begin
              err_d = 1'b1;
            end
          end
          PhPerm: begin
            if (char_code_i == ChR) begin
              perm_d = perm_d | PermRead;  started_d = 1'b1;
            end else if (char_code_i == ChW) begin
              perm_d = perm_d | PermWrite; started_d = 1'b1;
            end else if (char_code_i == ChX) begin
              perm_d = perm_d | PermExec;  started_d = 1'b1;
            end else if (char_code_i == ChS) begin
              perm_d = perm_d | PermSetid; started_d = 1'b1;
            end else if (char_code_i == ChT) begin
              perm_d = perm_d | PermStick; started_d = 1'b1;
            end else begin
              // copy letters only right after the operator
              if (!started_d) begin
                if (char_code_i == ChU) begin
                  cp = cur_d[8:6]; is_copy = 1'b1;
                end else if (char_code_i == ChG) begin
                  cp = cur_d[5:3]; is_copy = 1'b1;
                end else if (char_code_i == ChO) begin
                  cp = cur_d[2:0]; is_copy = 1'b1;
                end
              end
              if (is_copy) begin
                cur_d   = apply_op(op_d, {3'b000, cp, cp, cp}, who_d, cur_d);
                op_d    = OpNone;
                phase_d = PhCopied;
              end else if (opc != OpNone) begin
                cur_d = apply_op(op_d, perm_d, who_d, cur_d);
                if (who_d == '0) who_d = def_who;
                op_d      = opc;
                perm_d    = '0;
                started_d = 1'b0;
              end else if (char_code_i == ChComma) begin
                cur_d   = apply_op(op_d, perm_d, who_d, cur_d);
                who_d   = '0;
                op_d    = OpNone;
                phase_d = PhWho;
              end else begin
                err_d = 1'b1;
              end
            end
          end
          PhCopied: begin
            if (opc != OpNone) begin
              if (who_d == '0) who_d = def_who;
              op_d      = opc;
              perm_d    = '0;
              started_d = 1'b0;
              phase_d   = PhPerm;
            end else if (char_code_i == ChComma) begin
              who_d   = '0;
              op_d    = OpNone;
              phase_d = PhWho;
            end else begin
              err_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    // end of string: close pending clause, pick result, restart on saved mode
    if (!err_d && phase_d == PhPerm) begin
      out_mode_d = apply_op(op_d, perm_d, who_d, cur_d);
    end else if (!err_d && phase_d == PhDigits) begin
      out_mode_d = octal_d;
    end else begin
      out_mode_d = cur_d;
    end
    if (err_d) out_mode_d = saved_d;
    out_inv_d = err_d;

    if (last_char_i) begin
      phase_d   = PhDigits;
      octal_d   = '0;
      who_d     = '0;
      op_d      = OpNone;
      perm_d    = '0;
      started_d = 1'b0;
      cur_d     = saved_d;
      err_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      umask_q     <= UmaskReset;
      phase_q     <= PhDigits;
      octal_q     <= '0;
      who_q       <= '0;
      op_q        <= OpNone;
      perm_q      <= '0;
      started_q   <= 1'b0;
      cur_q       <= '0;
      err_q       <= 1'b0;
      saved_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) umask_q <= cfg_wdata_i;
      if (in_fire) begin
        phase_q   <= phase_d;
        octal_q   <= octal_d;
        who_q     <= who_d;
        op_q      <= op_d;
        perm_q    <= perm_d;
        started_q <= started_d;
        cur_q     <= cur_d;
        err_q     <= err_d;
        saved_q   <= saved_d;
      end
      if (in_fire && last_char_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_char_i) begin
      out_mode_q <= out_mode_d;
      out_inv_q  <= out_inv_d;
    end
  end

  `SFMP_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni,
                    in_fire && last_char_i, out_valid_o)
  `SFMP_ASSERT_NEXT(a_no_spurious_result, clk_i, rst_ni,
                    !(in_fire && last_char_i) && !out_valid_o, !out_valid_o)
  `SFMP_ASSERT_NEXT(a_error_freezes_mode, clk_i, rst_ni,
                    err_q && in_fire && !first_char_i && !last_char_i,
                    err_q && $stable(cur_q))
  `SFMP_ASSERT_NEXT(a_restart_after_result, clk_i, rst_ni,
                    in_fire && last_char_i,
                    !err_q && phase_q == PhDigits && cur_q == saved_q)

endmodule

`default_nettype wire
